FILE: src/lcdenc_pkg.sv
// Shared types, codes and helpers for the LCD draw-command encoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package lcdenc_pkg;

	typedef enum logic [1:0] {
		OP_POINT = 2'd0,
		OP_HLINE = 2'd1,
		OP_VLINE = 2'd2,
		OP_RECT  = 2'd3
	} op_t;

	localparam logic [1:0] KIND_COMMAND = 2'd0;
	localparam logic [1:0] KIND_DATA    = 2'd1;
	localparam logic [1:0] KIND_RUN     = 2'd2;

	localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
	localparam logic [7:0] CMD_ROW_SET      = 8'h2B;
	localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;
	localparam logic [7:0] ADDR_HIGH_BYTE   = 8'h00;

	localparam logic [1:0] CFG_COLUMN_OFFSET = 2'd0;
	localparam logic [1:0] CFG_ROW_OFFSET    = 2'd1;
	localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd2;
	localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd3;

	localparam logic [8:0] RESET_SCREEN_WIDTH  = 9'd128;
	localparam logic [8:0] RESET_SCREEN_HEIGHT = 9'd160;

	localparam int QUEUE_DEPTH    = 4;
	localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [7:0] column_offset;
		logic [7:0] row_offset;
		logic [8:0] screen_width;
		logic [8:0] screen_height;
	} cfg_t;

	// One window setup plus its optional pixel run; address bytes carry the offsets.
	typedef struct packed {
		logic [7:0]  left;
		logic [7:0]  right;
		logic [7:0]  top;
		logic [7:0]  bottom;
		logic [15:0] color;
		logic [16:0] count;
		logic        last;
	} prim_t;

	// Number of pixels from first to second inclusive, zero when reversed.
	function automatic logic [8:0] span(input logic signed [9:0] first,
			input logic signed [9:0] second);
		logic signed [9:0] diff;
		begin
			diff = second - first + 10'sd1;
			span = (second >= first) ? diff[8:0] : 9'd0;
		end
	endfunction

endpackage

`default_nettype wire

FILE: src/lcdenc_front.sv
// Front end: accepts draw requests and splits each into window primitives.
// Depends on lcdenc_pkg.
`default_nettype none

module lcdenc_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lcdenc_pkg::cfg_t   cfg,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         operation,
	input  wire logic [7:0]         x_first,
	input  wire logic [7:0]         y_first,
	input  wire logic [7:0]         x_second,
	input  wire logic [7:0]         y_second,
	input  wire logic [15:0]        line_color,
	input  wire logic [15:0]        fill_color,
	input  wire logic               fill_enable,
	output logic                    push_valid,
	input  wire logic               push_ready,
	output lcdenc_pkg::prim_t       prim
);
	import lcdenc_pkg::*;

	logic              hold_valid_q;
	logic [2:0]        step_q;
	op_t               op_q;
	logic [7:0]        xa_q, ya_q, xb_q, yb_q;
	logic [15:0]       line_q, fill_q;

	logic              accept, rect, fill_step, inset, drop, prim_last, done;
	logic              on_screen;
	logic signed [9:0] xa_e, ya_e, xb_e, yb_e, ins_e;
	logic signed [9:0] l, r, t, b;
	logic [16:0]       count_full;

	assign accept    = in_valid && in_ready;
	assign rect      = (op_q == OP_RECT);
	assign fill_step = rect && (step_q == 3'd0);
	assign inset     = fill_step && (line_q != fill_q);

	assign xa_e  = $signed({2'b00, xa_q});
	assign ya_e  = $signed({2'b00, ya_q});
	assign xb_e  = $signed({2'b00, xb_q});
	assign yb_e  = $signed({2'b00, yb_q});
	assign ins_e = $signed({9'd0, inset});

	always_comb begin
		l = xa_e;
		r = xa_e;
		t = ya_e;
		b = ya_e;
		unique case (op_q)
			OP_POINT: begin
			end
			OP_HLINE: begin
				r = xb_e;
			end
			OP_VLINE: begin
				b = yb_e;
			end
			OP_RECT: begin
				case (step_q)
					3'd0: begin
						l = xa_e + ins_e;
						r = xb_e - ins_e;
						t = ya_e + ins_e;
						b = yb_e - ins_e;
					end
					3'd1: begin
						r = xb_e;
					end
					3'd2: begin
						r = xb_e;
						t = yb_e;
						b = yb_e;
					end
					3'd3: begin
						b = yb_e;
					end
					default: begin
						l = xb_e;
						r = xb_e;
						b = yb_e;
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	assign count_full = {8'd0, span(t, b)} * {8'd0, span(l, r)};
	assign on_screen  = ({1'b0, xa_q} < cfg.screen_width) && ({1'b0, ya_q} < cfg.screen_height);
	assign drop       = (op_q == OP_POINT) && !on_screen;
	assign prim_last  = !rect || (step_q == 3'd4) || (fill_step && (line_q == fill_q));

	assign push_valid = hold_valid_q && !drop;
	assign done       = hold_valid_q && (drop || (push_ready && prim_last));
	assign in_ready   = !hold_valid_q || done;

	assign prim.left   = cfg.column_offset + l[7:0];
	assign prim.right  = cfg.column_offset + r[7:0];
	assign prim.top    = cfg.row_offset + t[7:0];
	assign prim.bottom = cfg.row_offset + b[7:0];
	assign prim.color  = fill_step ? fill_q : line_q;
	assign prim.count  = count_full;
	assign prim.last   = prim_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			step_q       <= 3'd0;
		end else if (accept) begin
			hold_valid_q <= 1'b1;
			step_q       <= ((op_t'(operation) == OP_RECT) && !fill_enable) ? 3'd1 : 3'd0;
		end else if (done) begin
			hold_valid_q <= 1'b0;
		end else if (push_valid && push_ready) begin
			step_q <= step_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_t'(operation);
			xa_q   <= x_first;
			ya_q   <= y_first;
			xb_q   <= x_second;
			yb_q   <= y_second;
			line_q <= line_color;
			fill_q <= fill_color;
		end
	end

endmodule

`default_nettype wire

FILE: src/lcdenc_queue.sv
// Short FIFO of primitives between the front and back ends.
// Depends on lcdenc_pkg for the primitive type and the depth.
`default_nettype none

module lcdenc_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push_valid,
	output logic                   push_ready,
	input  wire lcdenc_pkg::prim_t push_data,
	output logic                   pop_valid,
	input  wire logic              pop_ready,
	output lcdenc_pkg::prim_t      pop_data
);
	import lcdenc_pkg::*;

	prim_t                     mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_PTR_BITS:0]   count_q;
	logic                      do_push, do_pop;

	assign push_ready = (count_q != (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

FILE: src/lcdenc_back.sv
// Back end: turns each primitive into window setup bytes and a pixel run.
// Depends on lcdenc_pkg; drives the registered result channel.
`default_nettype none

module lcdenc_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              pop_valid,
	output logic                   pop_ready,
	input  wire lcdenc_pkg::prim_t pop_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [1:0]             item_kind,
	output logic [15:0]            item_value,
	output logic [16:0]            run_length,
	output logic                   last_item
);
	import lcdenc_pkg::*;

	localparam logic [3:0] ITEM_MEMORY_WRITE = 4'd10;
	localparam logic [3:0] ITEM_RUN          = 4'd11;

	prim_t       cur_q;
	logic        cur_valid_q;
	logic [3:0]  idx_q;
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [15:0] value_q;
	logic [16:0] len_q;
	logic        last_q;

	logic        advance, final_item;
	logic [1:0]  kind_d;
	logic [7:0]  byte_d;
	logic [15:0] value_d;
	logic [16:0] len_d;

	assign advance    = cur_valid_q && (!out_valid_q || out_ready);
	assign final_item = (idx_q == ITEM_RUN) ||
		((idx_q == ITEM_MEMORY_WRITE) && (cur_q.count == '0));
	assign pop_ready  = !cur_valid_q || (advance && final_item);

	always_comb begin
		kind_d = KIND_DATA;
		byte_d = ADDR_HIGH_BYTE;
		len_d  = '0;
		unique case (idx_q)
			4'd0: begin
				kind_d = KIND_COMMAND;
				byte_d = CMD_COLUMN_SET;
			end
			4'd2: byte_d = cur_q.left;
			4'd4: byte_d = cur_q.right;
			4'd5: begin
				kind_d = KIND_COMMAND;
				byte_d = CMD_ROW_SET;
			end
			4'd7: byte_d = cur_q.top;
			4'd9: byte_d = cur_q.bottom;
			ITEM_MEMORY_WRITE: begin
				kind_d = KIND_COMMAND;
				byte_d = CMD_MEMORY_WRITE;
			end
			ITEM_RUN: begin
				kind_d = KIND_RUN;
				len_d  = cur_q.count;
			end
			default: begin
			end
		endcase
		value_d = (idx_q == ITEM_RUN) ? cur_q.color : {8'd0, byte_d};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop_valid && pop_ready) begin
				cur_valid_q <= 1'b1;
				idx_q       <= 4'd0;
			end else if (advance && final_item) begin
				cur_valid_q <= 1'b0;
			end else if (advance) begin
				idx_q <= idx_q + 4'd1;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			cur_q <= pop_data;
		end
		if (advance) begin
			kind_q  <= kind_d;
			value_q <= value_d;
			len_q   <= len_d;
			last_q  <= cur_q.last && final_item;
		end
	end

	assign out_valid  = out_valid_q;
	assign item_kind  = kind_q;
	assign item_value = value_q;
	assign run_length = len_q;
	assign last_item  = last_q;

endmodule

`default_nettype wire

FILE: src/lcd_draw_command_encoder_top.sv
// Requests pass the front-end hold register, primitive queue and back-end output register.
// Throughput: each primitive takes 11 result items, 12 with a pixel run, one per cycle
// while out_ready is high, which sets the rate; a rectangle yields up to five primitives.
// A new request is accepted while the previous one is still being emitted.
// Reset empties the pipeline and sets offsets to 0, width to 128 and height to 160.
// Top level: configuration registers, front end, primitive queue and back end.
`default_nettype none

module lcd_draw_command_encoder_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [8:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic [7:0]  x_first,
	input  wire logic [7:0]  y_first,
	input  wire logic [7:0]  x_second,
	input  wire logic [7:0]  y_second,
	input  wire logic [15:0] line_color,
	input  wire logic [15:0] fill_color,
	input  wire logic        fill_enable,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       item_kind,
	output logic [15:0]      item_value,
	output logic [16:0]      run_length,
	output logic             last_item
);
	import lcdenc_pkg::*;

	cfg_t  cfg_q;
	prim_t front_prim, queue_prim;
	logic  front_valid, front_ready, queue_valid, queue_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.column_offset <= 8'd0;
			cfg_q.row_offset    <= 8'd0;
			cfg_q.screen_width  <= RESET_SCREEN_WIDTH;
			cfg_q.screen_height <= RESET_SCREEN_HEIGHT;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_COLUMN_OFFSET: cfg_q.column_offset <= cfg_data[7:0];
				CFG_ROW_OFFSET:    cfg_q.row_offset    <= cfg_data[7:0];
				CFG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data;
				CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	lcdenc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.x_first     (x_first),
		.y_first     (y_first),
		.x_second    (x_second),
		.y_second    (y_second),
		.line_color  (line_color),
		.fill_color  (fill_color),
		.fill_enable (fill_enable),
		.push_valid  (front_valid),
		.push_ready  (front_ready),
		.prim        (front_prim)
	);

	lcdenc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (front_prim),
		.pop_valid  (queue_valid),
		.pop_ready  (queue_ready),
		.pop_data   (queue_prim)
	);

	lcdenc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (queue_valid),
		.pop_ready  (queue_ready),
		.pop_data   (queue_prim),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.item_kind  (item_kind),
		.item_value (item_value),
		.run_length (run_length),
		.last_item  (last_item)
	);

endmodule

`default_nettype wire
